### src/scfl_pkg.sv
// ----------------------------------------------------------------------------
// scfl_pkg
// Shared types and constants for the size-class free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scfl_pkg;

  localparam int ADDR_W = 20;
  localparam int IDX_W  = 16;
  localparam int LINK_W = IDX_W + 1;
  localparam int SIZE_W = 9;
  localparam int OUT_W  = 17;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
  localparam logic [1:0] STATUS_NO_BLOCK = 2'd2;

  // link entry: valid flag above a chunk index
  typedef logic [LINK_W-1:0] link_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    link_t            data;
  } link_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } link_rd_t;

endpackage

`default_nettype wire

### src/scfl_link_ram.sv
// ----------------------------------------------------------------------------
// scfl_link_ram
// Next-chunk link store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_link_ram (
  input  logic              clk,
  input  scfl_pkg::link_wr_t wr,
  input  scfl_pkg::link_rd_t rd,
  output scfl_pkg::link_t    rdata
);

  scfl_pkg::link_t mem [2**scfl_pkg::IDX_W];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

### src/size_class_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_core
// Segregated free-list pool allocator with per-class list heads and a link RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on granted_address, status and pool_empty for one cycle with done
// high, and cannot be held off. A free, a bad-size request and an allocation
// that runs out of blocks finish in S_EXEC; an allocation served from a
// non-empty list goes on to S_POP, as the link RAM read adds a state. An
// allocation that finds its list empty carves a fresh block in S_CARVE,
// one chunk per cycle for chunk_count chunks, chaining them in the link RAM,
// where chunk_count = BLOCK_BYTES / chunk size, then ends in S_TAIL; so the
// carving walk through the link RAM sets the worst case, with the smallest
// class. There is no clearing pass after reset: list heads carry per-entry
// written flags, and links are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_free_list_allocator_core #(
  parameter int BLOCK_COUNT = 64,
  parameter int BLOCK_BYTES = 16384,
  parameter int SIZE_STEP   = 16,
  parameter int CLASS_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [scfl_pkg::SIZE_W-1:0]   request_size,
  input  logic [scfl_pkg::ADDR_W-1:0]   chunk_address,
  output logic                          done,
  output logic [scfl_pkg::ADDR_W-1:0]   granted_address,
  output logic [1:0]                    status,
  output logic                          pool_empty
);

  localparam int CLS_W    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int BLK_W    = $clog2(BLOCK_COUNT + 1);
  localparam int KW       = $clog2(BLOCK_BYTES / SIZE_STEP + 1);
  localparam int MAX_SIZE = SIZE_STEP * CLASS_COUNT;
  localparam int CSZ_W    = $clog2(MAX_SIZE + 1);
  // reciprocal multipliers: exact for 20-bit addresses and 9-bit sizes
  localparam int IDX_SH   = 28;
  localparam int IDX_MULT = (2**IDX_SH + SIZE_STEP - 1) / SIZE_STEP;
  localparam int CLS_SH   = 16;
  localparam int CLS_MULT = (2**CLS_SH + SIZE_STEP - 1) / SIZE_STEP;
  localparam int DIV_W    = scfl_pkg::ADDR_W + 27;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_CARVE,
    S_TAIL
  } state_t;

  state_t state;

  // per-class chunk count table, worked out at elaboration
  logic [KW-1:0] chunk_cnt_tbl [CLASS_COUNT];
  for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_cnt
    localparam int CNT = BLOCK_BYTES / ((g + 1) * SIZE_STEP);
    assign chunk_cnt_tbl[g] = KW'(CNT);
  end

  // request registers
  logic                         op_q;
  logic                         bad_q;
  logic [CLS_W-1:0]             cls_q;
  logic [scfl_pkg::IDX_W-1:0]   free_idx_q;

  // carving registers
  logic [scfl_pkg::ADDR_W-1:0]  carve_addr;
  logic [KW-1:0]                k_cnt;
  logic [KW-1:0]                cnt_q;
  logic [CSZ_W-1:0]             csize_q;
  logic [scfl_pkg::IDX_W-1:0]   prev_idx;
  scfl_pkg::link_t              new_head;

  logic [BLK_W-1:0]             blocks_in_use;
  logic [scfl_pkg::OUT_W-1:0]   outstanding;

  // list heads: small memory with written flags cleared by reset
  scfl_pkg::link_t              heads_mem [CLASS_COUNT];
  logic [CLASS_COUNT-1:0]       head_written;
  scfl_pkg::link_t              head_rd_data;
  logic                         head_rd_ok;
  scfl_pkg::link_t              head_cur;
  logic                         head_we;
  scfl_pkg::link_t              head_wdata;

  scfl_pkg::link_wr_t           link_wr;
  scfl_pkg::link_rd_t           link_rd;
  scfl_pkg::link_t              link_rdata;

  // ---- size decode: class and validity
  logic [scfl_pkg::SIZE_W-1:0]  size_m1;
  logic [23:0]                  cls_prod;
  logic [6:0]                   cls_raw;
  logic [CLS_W-1:0]             cls_in;
  logic                         bad_in;

  assign size_m1  = request_size - scfl_pkg::SIZE_W'(1);
  assign cls_prod = 24'(size_m1) * 24'(CLS_MULT);
  assign cls_raw  = cls_prod[CLS_SH+6:CLS_SH];
  assign cls_in   = (32'(cls_raw) >= CLASS_COUNT) ? CLS_W'(CLASS_COUNT - 1)
                                                  : cls_raw[CLS_W-1:0];
  assign bad_in   = (request_size == '0) || (32'(request_size) > MAX_SIZE);

  // ---- address to chunk index, shared by free decode and carving
  logic [scfl_pkg::ADDR_W-1:0]  div_in;
  logic [DIV_W-1:0]             div_prod;
  logic [scfl_pkg::IDX_W-1:0]   div_idx;

  assign div_in   = (state == S_CARVE) ? carve_addr : chunk_address;
  assign div_prod = DIV_W'(div_in) * DIV_W'(IDX_MULT);
  assign div_idx  = div_prod[IDX_SH+scfl_pkg::IDX_W-1:IDX_SH];

  function automatic logic [scfl_pkg::ADDR_W-1:0] idx_to_addr(
    input logic [scfl_pkg::IDX_W-1:0] idx
  );
    logic [31:0] prod;
    prod = 32'(idx) * 32'(SIZE_STEP);
    return prod[scfl_pkg::ADDR_W-1:0];
  endfunction

  logic [31:0]                  base_full;
  logic [scfl_pkg::OUT_W-1:0]   out_inc;
  logic [scfl_pkg::OUT_W-1:0]   out_dec;

  assign base_full = 32'(blocks_in_use) * 32'(BLOCK_BYTES);
  assign out_inc   = (outstanding == scfl_pkg::OUT_MAX) ? outstanding : outstanding + 1'b1;
  assign out_dec   = (outstanding == '0) ? outstanding : outstanding - 1'b1;
  assign head_cur  = head_rd_ok ? head_rd_data : '0;
  assign busy      = (state != S_IDLE);

  // ---- head memory: read on the accept cycle, write at the class of the request
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      head_rd_data <= heads_mem[cls_in];
      head_rd_ok   <= head_written[cls_in];
    end
    if (head_we) begin
      heads_mem[cls_q] <= head_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_written <= '0;
    end else if (head_we) begin
      head_written[cls_q] <= 1'b1;
    end
  end

  // ---- memory port control
  always_comb begin
    head_we       = 1'b0;
    head_wdata    = '0;
    link_wr.en    = 1'b0;
    link_wr.addr  = prev_idx;
    link_wr.data  = '0;
    link_rd.en    = 1'b0;
    link_rd.addr  = head_cur[scfl_pkg::IDX_W-1:0];
    case (state)
      S_EXEC: begin
        if (!bad_q && op_q == scfl_pkg::OP_FREE) begin
          // push: new chunk points at the old head
          link_wr.en   = 1'b1;
          link_wr.addr = free_idx_q;
          link_wr.data = head_cur;
          head_we      = 1'b1;
          head_wdata   = {1'b1, free_idx_q};
        end else if (!bad_q && head_cur[scfl_pkg::IDX_W]) begin
          link_rd.en = 1'b1;
        end
      end
      S_POP: begin
        head_we    = 1'b1;
        head_wdata = link_rdata;
      end
      S_CARVE: begin
        // chain the previous chunk to this one from the third chunk on
        if (32'(k_cnt) >= 2) begin
          link_wr.en   = 1'b1;
          link_wr.data = {1'b1, div_idx};
        end
      end
      S_TAIL: begin
        head_we    = 1'b1;
        head_wdata = new_head;
        if (32'(cnt_q) >= 2) begin
          link_wr.en   = 1'b1;
          link_wr.data = '0;
        end
      end
      default: ;
    endcase
  end

  scfl_link_ram u_link_ram (
    .clk   (clk),
    .wr    (link_wr),
    .rd    (link_rd),
    .rdata (link_rdata)
  );

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      blocks_in_use <= '0;
      outstanding   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q       <= operation;
            bad_q      <= bad_in;
            cls_q      <= cls_in;
            free_idx_q <= div_idx;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (bad_q) begin
            done            <= 1'b1;
            granted_address <= '0;
            status          <= scfl_pkg::STATUS_BAD_SIZE;
            pool_empty      <= (outstanding == '0);
            state           <= S_IDLE;
          end else if (op_q == scfl_pkg::OP_FREE) begin
            outstanding     <= out_dec;
            done            <= 1'b1;
            granted_address <= '0;
            status          <= scfl_pkg::STATUS_OK;
            pool_empty      <= (out_dec == '0);
            state           <= S_IDLE;
          end else if (head_cur[scfl_pkg::IDX_W]) begin
            granted_address <= idx_to_addr(head_cur[scfl_pkg::IDX_W-1:0]);
            state           <= S_POP;
          end else if (32'(blocks_in_use) >= BLOCK_COUNT || chunk_cnt_tbl[cls_q] == '0) begin
            done            <= 1'b1;
            granted_address <= '0;
            status          <= scfl_pkg::STATUS_NO_BLOCK;
            pool_empty      <= (outstanding == '0);
            state           <= S_IDLE;
          end else begin
            carve_addr <= base_full[scfl_pkg::ADDR_W-1:0];
            k_cnt      <= '0;
            cnt_q      <= chunk_cnt_tbl[cls_q];
            csize_q    <= CSZ_W'((32'(cls_q) + 1) * SIZE_STEP);
            new_head   <= '0;
            state      <= S_CARVE;
          end
        end
        S_POP: begin
          outstanding <= out_inc;
          done        <= 1'b1;
          status      <= scfl_pkg::STATUS_OK;
          pool_empty  <= (out_inc == '0);
          state       <= S_IDLE;
        end
        S_CARVE: begin
          // chunk 0 is granted, chunk 1 becomes the new head
          if (k_cnt == '0) begin
            granted_address <= idx_to_addr(div_idx);
          end
          if (32'(k_cnt) == 1) begin
            new_head <= {1'b1, div_idx};
          end
          prev_idx   <= div_idx;
          carve_addr <= carve_addr + scfl_pkg::ADDR_W'(csize_q);
          if (32'(k_cnt) == 32'(cnt_q) - 1) begin
            state <= S_TAIL;
          end else begin
            k_cnt <= k_cnt + 1'b1;
          end
        end
        S_TAIL: begin
          blocks_in_use <= blocks_in_use + 1'b1;
          outstanding   <= out_inc;
          done          <= 1'b1;
          status        <= scfl_pkg::STATUS_OK;
          pool_empty    <= (out_inc == '0);
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while a request is still in flight");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && status != scfl_pkg::STATUS_OK) |-> (granted_address == '0))
    else $error("failed request carries an address");

  a_blocks_bound: assert property (@(posedge clk) disable iff (rst)
    32'(blocks_in_use) <= BLOCK_COUNT)
    else $error("more blocks carved than the pool holds");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_carve_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAIL) |=> (blocks_in_use == $past(blocks_in_use) + 1'b1))
    else $error("carve finished without consuming a block");

endmodule

`default_nettype wire
